### src/assert_macros.svh
// Assertion macros shared by the beacon table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Checked property, disabled while reset is asserted (active low).
`define APBT_ASSERT(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("%m: assertion failed");
// Checked property that also holds through reset.
`define APBT_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) prop) \
        else $error("%m: assertion failed");
`else
`define APBT_ASSERT(lbl, clk, rstn, prop)
`define APBT_ASSERT_ALWAYS(lbl, clk, prop)
`endif
`endif

### src/apbt_pkg.sv
// Types, constants and helper functions of the beacon table.
package apbt_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int COUNT_W     = 24;
    localparam int ADDR_W      = 48;

    // frame control decode values
    localparam logic [1:0] BEACON_TYPE    = 2'h0;
    localparam logic [3:0] BEACON_SUBTYPE = 4'h8;
    localparam logic [1:0] DATA_TYPE      = 2'h2;
    localparam int         FLAG_TO_DS     = 0;
    localparam int         FLAG_FROM_DS   = 1;

    // operation carried by one frame
    localparam logic [1:0] OP_NONE   = 2'd0;
    localparam logic [1:0] OP_BEACON = 2'd1;
    localparam logic [1:0] OP_DATA   = 2'd2;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};
    localparam logic [COUNT_W-1:0] COUNT_ONE = {{(COUNT_W-1){1'b0}}, 1'b1};

    typedef struct packed {
        logic [1:0]        frame_type;
        logic [3:0]        frame_subtype;
        logic [7:0]        frame_flags;
        logic [ADDR_W-1:0] bss_id;
        logic signed [7:0] signal_dbm;
    } in_word_t;

    typedef struct packed {
        logic               hit;
        logic               inserted;
        logic               dropped_full;
        logic [6:0]         entry_index;
        logic signed [7:0]  entry_power;
        logic [COUNT_W-1:0] beacon_total;
        logic [COUNT_W-1:0] data_total;
        logic [7:0]         entries_used;
    } out_word_t;

    // one table entry, held by one cell of the ring
    typedef struct packed {
        logic [ADDR_W-1:0]  bss_id;
        logic signed [7:0]  power;
        logic [COUNT_W-1:0] beacon_cnt;
        logic [COUNT_W-1:0] data_cnt;
    } entry_t;

    // frame under search
    typedef struct packed {
        logic [1:0]        op;
        logic [ADDR_W-1:0] bss_id;
        logic signed [7:0] power;
    } job_t;

    // match report from the head unit
    typedef struct packed {
        logic   hit;
        entry_t entry;
    } head_hit_t;

    function automatic logic [1:0] decode_op(input in_word_t w);
        logic [1:0] op;
        op = OP_NONE;
        if (w.frame_type == BEACON_TYPE && w.frame_subtype == BEACON_SUBTYPE) begin
            op = OP_BEACON;
        end else if (w.frame_type == DATA_TYPE && w.frame_flags[FLAG_FROM_DS] &&
                     !w.frame_flags[FLAG_TO_DS]) begin
            op = OP_DATA;
        end
        return op;
    endfunction

    function automatic logic [COUNT_W-1:0] sat_inc(input logic [COUNT_W-1:0] v);
        return (v == COUNT_MAX) ? COUNT_MAX : v + COUNT_ONE;
    endfunction

    // index reported modulo 2^7
    function automatic logic [6:0] idx_to_out(input logic [IDX_W-1:0] idx);
        logic [IDX_W+6:0] wide;
        wide = {7'd0, idx};
        return wide[6:0];
    endfunction

    // entry count reported modulo 2^8
    function automatic logic [7:0] cnt_to_out(input logic [CNT_W-1:0] cnt);
        logic [CNT_W+7:0] wide;
        wide = {8'd0, cnt};
        return wide[7:0];
    endfunction

endpackage

### src/apbt_cell.sv
// One cell of the entry ring: holds one table entry and passes it on.
module apbt_cell
    import apbt_pkg::*;
(
    input  logic   aclk,
    input  logic   shift_en,
    input  entry_t entry_in,
    output entry_t entry_q
);

    entry_t entry_reg;

    // take the neighbor's entry on every rotation step
    always_ff @(posedge aclk) begin
        if (shift_en) begin
            entry_reg <= entry_in;
        end
    end

    assign entry_q = entry_reg;

endmodule

### src/apbt_head.sv
// Compare and update unit at the head of the entry ring.
module apbt_head
    import apbt_pkg::*;
(
    input  job_t             job,
    input  logic [IDX_W-1:0] step,
    input  logic [CNT_W-1:0] count,
    input  entry_t           entry_in,
    output entry_t           entry_out,
    output head_hit_t        hit_info
);

    logic   slot_used;
    logic   match;
    logic   ins_slot;
    entry_t upd;

    always_comb begin
        // entry at the head has original index = step
        slot_used = CNT_W'(step) < count;
        match     = slot_used && (job.op != OP_NONE) && (entry_in.bss_id == job.bss_id);
        // a beacon writes its candidate entry at the first free slot;
        // it only becomes valid if the count is bumped at the end
        ins_slot  = (job.op == OP_BEACON) && (CNT_W'(step) == count);

        upd = entry_in;
        if (match) begin
            upd.power = job.power;
            if (job.op == OP_BEACON) begin
                upd.beacon_cnt = sat_inc(entry_in.beacon_cnt);
            end else begin
                upd.data_cnt = sat_inc(entry_in.data_cnt);
            end
        end
        if (ins_slot) begin
            upd.bss_id     = job.bss_id;
            upd.power      = job.power;
            upd.beacon_cnt = COUNT_ONE;
            upd.data_cnt   = '0;
        end
    end

    assign entry_out      = upd;
    assign hit_info.hit   = match;
    assign hit_info.entry = upd;

endmodule

### src/access_point_beacon_table_core.sv
// Top level of the beacon table: entry ring, head unit and control.
//
//  channel | direction | handshake         | word
//  --------+-----------+-------------------+-----------
//  s_      | in        | s_valid / s_ready | in_word_t
//  m_      | out       | m_valid / m_ready | out_word_t
//
// Beacons and qualifying data frames rotate the entry ring once past the
// compare unit, one entry per cycle, then the result is written to the
// output register. Other frames skip the scan and go straight to the
// output register. A new word is taken while a result waits.
// Reset clears the control state and the entry count; entries need no clear.
// A stalled output holds the finished result; the next scan may run meanwhile.
`include "assert_macros.svh"
module access_point_beacon_table_core
    import apbt_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_word_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_word_t m_data
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    localparam logic [IDX_W-1:0] LAST_STEP = IDX_W'(TABLE_DEPTH - 1);
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);
    localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);

    logic [1:0]       state_reg, state_next;
    logic [IDX_W-1:0] step_reg, step_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             m_valid_reg, m_valid_next;
    out_word_t        m_data_reg, m_data_next;
    job_t             job_reg;
    logic             hit_reg;
    logic [IDX_W-1:0] idx_reg;
    entry_t           res_entry_reg;

    logic             accept;
    logic             shift_en;
    logic             out_free;
    entry_t           head_out;
    head_hit_t        hit_info;
    entry_t           ring [TABLE_DEPTH];
    job_t             job_in;

    assign accept   = s_valid && s_ready;
    assign s_ready  = (state_reg == ST_IDLE);
    assign shift_en = (state_reg == ST_SCAN);
    assign out_free = !m_valid_reg || m_ready;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    assign job_in.op     = decode_op(s_data);
    assign job_in.bss_id = s_data.bss_id;
    assign job_in.power  = s_data.signal_dbm;

    // entry ring: cell 0 feeds the head, the head feeds the last cell
    genvar gi;
    generate
        for (gi = 0; gi < TABLE_DEPTH; gi++) begin : g_cell
            if (gi == TABLE_DEPTH - 1) begin : g_tail
                apbt_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (shift_en),
                    .entry_in (head_out),
                    .entry_q  (ring[gi])
                );
            end else begin : g_body
                apbt_cell u_cell (
                    .aclk     (aclk),
                    .shift_en (shift_en),
                    .entry_in (ring[gi+1]),
                    .entry_q  (ring[gi])
                );
            end
        end
    endgenerate

    apbt_head u_head (
        .job       (job_reg),
        .step      (step_reg),
        .count     (count_reg),
        .entry_in  (ring[0]),
        .entry_out (head_out),
        .hit_info  (hit_info)
    );

    // control sequencing and result assembly
    always_comb begin
        state_next   = state_reg;
        step_next    = step_reg;
        count_next   = count_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                step_next = '0;
                if (accept) begin
                    state_next = (job_in.op == OP_NONE) ? ST_DONE : ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (step_reg == LAST_STEP) begin
                    step_next  = '0;
                    state_next = ST_DONE;
                end else begin
                    step_next = step_reg + IDX_W'(1);
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    m_data_next = '0;
                    if (hit_reg) begin
                        m_data_next.hit          = 1'b1;
                        m_data_next.entry_index  = idx_to_out(idx_reg);
                        m_data_next.entry_power  = res_entry_reg.power;
                        m_data_next.beacon_total = res_entry_reg.beacon_cnt;
                        m_data_next.data_total   = res_entry_reg.data_cnt;
                    end else if (job_reg.op == OP_BEACON) begin
                        if (count_reg < DEPTH_CNT) begin
                            m_data_next.inserted     = 1'b1;
                            m_data_next.entry_index  = idx_to_out(count_reg[IDX_W-1:0]);
                            m_data_next.entry_power  = job_reg.power;
                            m_data_next.beacon_total = COUNT_ONE;
                            count_next               = count_reg + CNT_ONE;
                        end else begin
                            m_data_next.dropped_full = 1'b1;
                        end
                    end
                    m_data_next.entries_used = cnt_to_out(count_next);
                    m_valid_next             = 1'b1;
                    state_next               = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            step_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            hit_reg     <= 1'b0;
        end else begin
            state_reg   <= state_next;
            step_reg    <= step_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            if (accept) begin
                hit_reg <= 1'b0;
            end else if (shift_en && hit_info.hit) begin
                hit_reg <= 1'b1;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        if (accept) begin
            job_reg <= job_in;
        end
        if (shift_en && hit_info.hit) begin
            idx_reg       <= step_reg;
            res_entry_reg <= hit_info.entry;
        end
    end

    // checks
    `APBT_ASSERT(a_count_bound, aclk, aresetn, count_reg <= DEPTH_CNT)
    `APBT_ASSERT(a_idle_step, aclk, aresetn, (state_reg != ST_SCAN) |-> (step_reg == '0))
    `APBT_ASSERT(a_full_turn, aclk, aresetn, (state_reg == ST_SCAN && state_next == ST_DONE) |-> (step_reg == LAST_STEP))
    `APBT_ASSERT(a_one_outcome, aclk, aresetn, m_valid_reg |-> $onehot0({m_data_reg.hit, m_data_reg.inserted, m_data_reg.dropped_full}))
    `APBT_ASSERT(a_hit_needs_op, aclk, aresetn, hit_reg |-> (job_reg.op != OP_NONE))

endmodule

### verif/access_point_beacon_table_core_test.sv
// Self-checking testbench of the beacon table core: random frames, scoreboard, stalls.
`timescale 1ns / 1ps

module access_point_beacon_table_core_test
    import apbt_pkg::*;
();

    // Tracks the beacon table as the core should hold it and checks every result word.
    class beacon_table_tracker;
        logic [ADDR_W-1:0]  addr_tab   [TABLE_DEPTH];
        logic signed [7:0]  power_tab  [TABLE_DEPTH];
        logic [COUNT_W-1:0] beacon_tab [TABLE_DEPTH];
        logic [COUNT_W-1:0] data_tab   [TABLE_DEPTH];
        int                 used;
        out_word_t          expected_reports[$];
        int                 errors;

        function new();
            used   = 0;
            errors = 0;
        endfunction

        // Apply one frame to the tracked table and return the result word it should give.
        function out_word_t predict_report(input in_word_t w);
            logic [1:0] op;
            int         idx;
            out_word_t  r;
            r   = '0;
            idx = -1;
            op  = OP_NONE;
            if (w.frame_type == BEACON_TYPE && w.frame_subtype == BEACON_SUBTYPE) begin
                op = OP_BEACON;
            end else if (w.frame_type == DATA_TYPE && w.frame_flags[FLAG_FROM_DS] &&
                         !w.frame_flags[FLAG_TO_DS]) begin
                op = OP_DATA;
            end

            // linear search over the valid entries only
            if (op != OP_NONE) begin
                for (int i = 0; i < used; i++) begin
                    if (idx < 0 && addr_tab[i] == w.bss_id) begin
                        idx = i;
                    end
                end
            end

            if (idx >= 0) begin
                r.hit = 1'b1;
            end else if (op == OP_BEACON) begin
                if (used < TABLE_DEPTH) begin
                    idx             = used;
                    addr_tab[idx]   = w.bss_id;
                    beacon_tab[idx] = '0;
                    data_tab[idx]   = '0;
                    used++;
                    r.inserted = 1'b1;
                end else begin
                    r.dropped_full = 1'b1;
                end
            end

            // touched entry: store signal, bump the matching counter (saturating)
            if (idx >= 0) begin
                power_tab[idx] = w.signal_dbm;
                if (op == OP_BEACON) begin
                    beacon_tab[idx] = (beacon_tab[idx] == COUNT_MAX) ? COUNT_MAX
                                                                     : beacon_tab[idx] + 1'b1;
                end else begin
                    data_tab[idx] = (data_tab[idx] == COUNT_MAX) ? COUNT_MAX
                                                                 : data_tab[idx] + 1'b1;
                end
                r.entry_index  = 7'(idx);
                r.entry_power  = power_tab[idx];
                r.beacon_total = beacon_tab[idx];
                r.data_total   = data_tab[idx];
            end
            r.entries_used = 8'(used);
            return r;
        endfunction

        function void note_frame(input in_word_t w);
            expected_reports.push_back(predict_report(w));
        endfunction

        function void check_field(input string name, input logic [31:0] want,
                                  input logic [31:0] got);
            if (got !== want) begin
                $error("field %s: expected %0h, got %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_report(input out_word_t got);
            out_word_t want;
            if (expected_reports.size() == 0) begin
                $error("result word with no frame pending");
                errors++;
                return;
            end
            want = expected_reports.pop_front();
            check_field("hit",          32'(want.hit),          32'(got.hit));
            check_field("inserted",     32'(want.inserted),     32'(got.inserted));
            check_field("dropped_full", 32'(want.dropped_full), 32'(got.dropped_full));
            check_field("entry_index",  32'(want.entry_index),  32'(got.entry_index));
            check_field("entry_power",  32'(want.entry_power),  32'(got.entry_power));
            check_field("beacon_total", 32'(want.beacon_total), 32'(got.beacon_total));
            check_field("data_total",   32'(want.data_total),   32'(got.data_total));
            check_field("entries_used", 32'(want.entries_used), 32'(got.entries_used));
        endfunction
    endclass

    localparam int HOLD_CYCLES     = 3000;
    localparam int LIMIT_CYCLES    = 1200000;
    localparam int ITEMS_PER_PHASE = 333;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_word_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_word_t m_data;

    beacon_table_tracker tracker;

    int sender_idle_pct = 0;
    int ready_stall_pct = 0;
    bit hold_req        = 1'b0;
    bit hold_taken      = 1'b0;
    int hold_left       = 0;
    int cycles          = 0;

    always #6 aclk = ~aclk;

    access_point_beacon_table_core i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Receiver: random stalls, plus one long hold-off counted here
    always @(negedge aclk) begin
        if (hold_req && !hold_taken) begin
            hold_taken = 1'b1;
            hold_left  = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(99) >= ready_stall_pct);
        end
    end

    // Handshake monitor: note accepted frames, check accepted result words
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_valid && s_ready) begin
                tracker.note_frame(s_data);
            end
            if (m_valid && m_ready) begin
                tracker.check_report(m_data);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT_CYCLES) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic in_word_t build_frame(input logic [1:0] ftype, input logic [3:0] fsub,
                                             input logic [7:0] flags,
                                             input logic [ADDR_W-1:0] addr,
                                             input logic signed [7:0] sig);
        in_word_t w;
        w.frame_type    = ftype;
        w.frame_subtype = fsub;
        w.frame_flags   = flags;
        w.bss_id        = addr;
        w.signal_dbm    = sig;
        return w;
    endfunction

    // Offer one word after a random gap; returns at the falling edge after acceptance.
    task automatic send_frame(input in_word_t w);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_idle_pct) begin
            gap++;
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= w;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
    endtask

    initial begin
        in_word_t          w;
        int                kind;
        logic [63:0]       raw;
        logic [ADDR_W-1:0] ones;
        tracker = new();
        ones    = '1;

        repeat (10) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // directed: empty table, extremes, every frame class
        send_frame(build_frame(DATA_TYPE, 4'h0, 8'h02, '0, 8'sd5));
        send_frame(build_frame(BEACON_TYPE, BEACON_SUBTYPE, 8'h00, '0, -8'sd128));
        send_frame(build_frame(BEACON_TYPE, BEACON_SUBTYPE, 8'hFF, ones, 8'sd127));
        send_frame(build_frame(BEACON_TYPE, BEACON_SUBTYPE, 8'h00, '0, -8'sd1));
        send_frame(build_frame(DATA_TYPE, 4'h0, 8'h02, ones, 8'sd0));
        // data direction: ToDS set or FromDS clear is not counted
        send_frame(build_frame(DATA_TYPE, 4'h0, 8'hFF, ones, 8'sd1));
        send_frame(build_frame(DATA_TYPE, 4'h0, 8'h01, ones, 8'sd2));
        send_frame(build_frame(DATA_TYPE, 4'h0, 8'h00, ones, 8'sd3));
        send_frame(build_frame(DATA_TYPE, 4'h0, 8'h03, ones, 8'sd4));
        // other flag bits and any subtype still count
        send_frame(build_frame(DATA_TYPE, 4'hF, 8'hFE, ones, -8'sd100));
        send_frame(build_frame(DATA_TYPE, 4'h8, 8'hFE, '0, -8'sd1));
        // other frames leave the table alone
        send_frame(build_frame(2'd1, BEACON_SUBTYPE, 8'h02, '0, 8'sd9));
        send_frame(build_frame(2'd3, BEACON_SUBTYPE, 8'h02, ones, 8'sd9));
        send_frame(build_frame(BEACON_TYPE, 4'h0, 8'h00, '0, 8'sd9));
        send_frame(build_frame(BEACON_TYPE, 4'hF, 8'hFF, ones, 8'sd9));
        send_frame(build_frame(BEACON_TYPE, 4'h9, 8'h02, 48'h123456789ABC, 8'sd9));
        // data to an unknown BSSID misses, then a third entry appears
        send_frame(build_frame(DATA_TYPE, 4'h4, 8'h02, 48'h123456789ABC, 8'sd9));
        send_frame(build_frame(BEACON_TYPE, BEACON_SUBTYPE, 8'h55, 48'h123456789ABC, -8'sd1));
        send_frame(build_frame(DATA_TYPE, 4'h4, 8'hAA, 48'h123456789ABC, 8'sd20));

        // random phases: long receiver hold-off, sender idle, receiver stall, both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin
                    sender_idle_pct = 0;
                    ready_stall_pct <= 0;
                    hold_req        <= 1'b1;
                end
                1: begin
                    sender_idle_pct = 82;
                    ready_stall_pct <= 0;
                end
                2: begin
                    sender_idle_pct = 0;
                    ready_stall_pct <= 82;
                end
                default: begin
                    sender_idle_pct = 23;
                    ready_stall_pct <= 23;
                end
            endcase
            repeat (ITEMS_PER_PHASE) begin
                kind            = $urandom_range(99);
                raw             = {$urandom(), $urandom()};
                w.frame_type    = 2'($urandom());
                w.frame_subtype = 4'($urandom());
                w.frame_flags   = 8'($urandom());
                w.signal_dbm    = 8'($urandom());
                if ($urandom_range(9) == 0) begin
                    w.signal_dbm = -8'sd1;
                end
                // known BSSIDs give hits; fresh ones grow the table until it is full
                if (tracker.used > 0 && $urandom_range(99) < 60) begin
                    w.bss_id = tracker.addr_tab[$urandom_range(tracker.used - 1)];
                end else begin
                    w.bss_id = raw[ADDR_W-1:0];
                end
                if (kind < 45) begin
                    w.frame_type    = BEACON_TYPE;
                    w.frame_subtype = BEACON_SUBTYPE;
                end else if (kind < 75) begin
                    w.frame_type                = DATA_TYPE;
                    w.frame_flags[FLAG_FROM_DS] = 1'b1;
                    w.frame_flags[FLAG_TO_DS]   = 1'b0;
                end
                send_frame(w);
            end
        end
        s_valid <= 1'b0;

        // drain, then give a spurious word time to show up
        while (tracker.expected_reports.size() != 0) @(posedge aclk);
        repeat (2 * TABLE_DEPTH + 8) @(posedge aclk);
        if (tracker.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule

### files.f
+incdir+src
src/apbt_pkg.sv
src/apbt_cell.sv
src/apbt_head.sv
src/access_point_beacon_table_core.sv
verif/access_point_beacon_table_core_test.sv
